/* rtl/bba_pkg.sv */
package bba_pkg;

	localparam int POS_W      = 11;
	localparam int IDX_W      = 10;
	localparam int WORD_BITS  = 64;
	localparam int BIT_W      = 6;
	localparam int WIDX_W     = POS_W - BIT_W;

	localparam logic [1:0] FUNC_FIND = 2'd0;
	localparam logic [1:0] FUNC_SET  = 2'd1;
	localparam logic [1:0] FUNC_TEST = 2'd2;

	localparam logic [POS_W-1:0] BITS_IN_USE_RST = 11'd1024;

	typedef struct packed {
		logic [1:0]       func;
		logic [POS_W-1:0] position;
		logic             status;
	} req_t;

	typedef struct packed {
		logic             error;
		logic             found;
		logic [IDX_W-1:0] found_index;
		logic             is_free;
	} rsp_t;

	typedef enum logic [1:0] {
		EK_DONE,
		EK_FIND,
		EK_RMW
	} eval_kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL,
		ST_SCAN,
		ST_MODIFY,
		ST_RESULT
	} ctl_state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic eval;
		logic scan;
		logic modify;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic       clear_done;
		eval_kind_t kind;
		logic       scan_done;
		logic       out_busy;
	} sts_t;

endpackage

/* rtl/bba_ram.sv */
module bba_ram import bba_pkg::*; #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/bba_ctl.sv */
module bba_ctl import bba_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				case (sts.kind)
					EK_FIND: state_d = ST_SCAN;
					EK_RMW:  state_d = ST_MODIFY;
					default: state_d = ST_RESULT;
				endcase
			end
			ST_SCAN: begin
				if (sts.scan_done) state_d = ST_RESULT;
			end
			ST_MODIFY: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!sts.out_busy) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_CLEAR:  cmd.clear = 1'b1;
			ST_IDLE: begin
				req_stall = 1'b0;
				cmd.accept = req_valid;
			end
			ST_EVAL:   cmd.eval = 1'b1;
			ST_SCAN:   cmd.scan = 1'b1;
			ST_MODIFY: cmd.modify = 1'b1;
			ST_RESULT: cmd.load_out = !sts.out_busy;
			default:   cmd = '0;
		endcase
	end

endmodule

/* rtl/bba_dp.sv */
module bba_dp import bba_pkg::*; #(
	parameter int MAX_BITS = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  req_t             req,
	input  logic             cfg_wr_en,
	input  logic [POS_W-1:0] cfg_wr_data,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp
);

	localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WA = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam logic [31:0] MAXB = 32'(MAX_BITS);
	localparam logic [WA-1:0] LAST_WORD = WA'(WORD_COUNT - 1);

	logic [POS_W-1:0]     bits_q;
	logic [WA-1:0]        clr_cnt_q;
	req_t                 req_q;
	logic [WIDX_W-1:0]    chk_q;
	rsp_t                 res_q;
	rsp_t                 out_q;
	logic                 out_valid_q;

	logic [POS_W-1:0]     n;
	logic [POS_W-1:0]     n_m1;
	logic [WIDX_W-1:0]    last_word;
	logic [BIT_W-1:0]     last_bit;
	logic [WIDX_W-1:0]    pos_word;
	logic [BIT_W-1:0]     pos_bit;
	eval_kind_t           kind;
	logic                 imm_err;

	logic                 ram_we;
	logic [WA-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [WA-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	logic [WORD_BITS-1:0] lo_mask;
	logic [WORD_BITS-1:0] hi_mask;
	logic [WORD_BITS-1:0] match;
	logic                 hit;
	logic [BIT_W-1:0]     enc;
	logic [POS_W-1:0]     hit_idx;
	logic [WORD_BITS-1:0] bit_mask;

	assign n = ({21'd0, bits_q} > MAXB) ? MAXB[POS_W-1:0] : bits_q;
	assign n_m1 = n - 11'd1;
	assign last_word = n_m1[POS_W-1:BIT_W];
	assign last_bit = n_m1[BIT_W-1:0];
	assign pos_word = req_q.position[POS_W-1:BIT_W];
	assign pos_bit = req_q.position[BIT_W-1:0];

	always_comb begin
		kind = EK_DONE;
		imm_err = 1'b0;
		case (req_q.func)
			FUNC_FIND: begin
				if (req_q.position > n) imm_err = 1'b1;
				else if (req_q.position != n) kind = EK_FIND;
			end
			FUNC_SET, FUNC_TEST: begin
				if (req_q.position >= n) imm_err = 1'b1;
				else kind = EK_RMW;
			end
			default: imm_err = 1'b1;
		endcase
	end

	// find: mask off bits below the start and at or past the end
	always_comb begin
		lo_mask = (chk_q == pos_word) ? ({WORD_BITS{1'b1}} << pos_bit) : {WORD_BITS{1'b1}};
		hi_mask = (chk_q == last_word) ? ({WORD_BITS{1'b1}} >> (6'd63 - last_bit))
			: {WORD_BITS{1'b1}};
		match = (req_q.status ? ram_rdata : ~ram_rdata) & lo_mask & hi_mask;
		hit = |match;
	end

	always_comb begin
		enc = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (match[i]) enc = BIT_W'(i);
		end
	end

	assign hit_idx = {chk_q, enc};
	assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << pos_bit;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = WA'(pos_word);
		ram_wdata = (ram_rdata & ~bit_mask) | (req_q.status ? bit_mask : '0);
		if (cmd.clear) begin
			ram_we = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else if (cmd.modify && req_q.func == FUNC_SET) begin
			ram_we = 1'b1;
		end
		ram_raddr = cmd.scan ? WA'(chk_q + 5'd1) : WA'(pos_word);
	end

	bba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WORD_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= BITS_IN_USE_RST;
			clr_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) bits_q <= cfg_wr_data;
			if (cmd.clear) clr_cnt_q <= clr_cnt_q + WA'(1);
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!rsp_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) req_q <= req;
		if (cmd.eval) begin
			chk_q <= pos_word;
			res_q <= '{error: imm_err, found: 1'b0, found_index: '0, is_free: 1'b0};
		end
		if (cmd.scan) begin
			chk_q <= chk_q + 5'd1;
			res_q <= '{error: 1'b0, found: hit,
				found_index: hit ? hit_idx[IDX_W-1:0] : '0, is_free: 1'b0};
		end
		if (cmd.modify) begin
			res_q <= '{error: 1'b0, found: 1'b0, found_index: '0,
				is_free: (req_q.func == FUNC_TEST) ? ~ram_rdata[pos_bit] : 1'b0};
		end
		if (cmd.load_out) out_q <= res_q;
	end

	assign sts.clear_done = (clr_cnt_q == LAST_WORD);
	assign sts.kind = kind;
	assign sts.scan_done = hit || (chk_q == last_word);
	assign sts.out_busy = out_valid_q && rsp_stall;

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

endmodule

/* rtl/block_bitmap_allocator.sv */
// Block allocation bitmap of MAX_BITS bits held in a RAM of 64-bit words. After reset
// a clearing pass writes zero to one word per cycle over all ceil(MAX_BITS/64) words
// (16 at the default), during which no request word is taken; bits_in_use may be written
// at any idle time. Each request gives exactly one response word. An out-of-range or
// unused operation goes straight from evaluation to the response, set and test do one RAM
// read, then write-back or check, and find scans bitmap words from the start word on,
// at most 16 words for 1024 bits in use: the scan reads one word per cycle from the
// single RAM read port and runs it through a 64-bit priority encoder. A new request is
// taken once the previous response has been placed in the output register.
module block_bitmap_allocator import bba_pkg::*; #(
	parameter int MAX_BITS = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             cfg_wr_en,
	input  logic [POS_W-1:0] cfg_wr_data
);

	cmd_t cmd;
	sts_t sts;

	bba_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bba_dp #(
		.MAX_BITS(MAX_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req         (req),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp)
	);

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(rsp_valid && rsp_stall))
		else $error("response loaded over a pending word");

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> cmd.eval)
		else $error("accepted word not evaluated");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.accept, cmd.eval, cmd.scan, cmd.modify, cmd.load_out}))
		else $error("conflicting datapath commands");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> req_stall)
		else $error("request taken during clearing pass");

endmodule
